### rtl/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// shared command codes, step command and status types for the i2c master
// bit sequencer
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    localparam int unsigned BYTE_BITS = 8;

    // bus command codes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_SEND  = 3'd2;
    localparam logic [2:0] OP_RECV  = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;
    localparam logic [2:0] OP_NACK  = 3'd5;

    // hold times in microseconds
    localparam logic [2:0] HOLD_0 = 3'd0;
    localparam logic [2:0] HOLD_1 = 3'd1;
    localparam logic [2:0] HOLD_4 = 3'd4;
    localparam logic [2:0] HOLD_5 = 3'd5;

    // step counter covers the longest run (send byte, 26 steps)
    localparam int unsigned CNT_W = 5;
    localparam logic [CNT_W-1:0] SEND_LAST = CNT_W'(3 * BYTE_BITS + 1);
    localparam logic [CNT_W-1:0] SEND_TAIL = CNT_W'(3 * BYTE_BITS);
    localparam logic [CNT_W-1:0] RECV_LAST = CNT_W'(2 * BYTE_BITS + 1);

    // sda source select
    localparam logic [1:0] SDA_HELD = 2'd0;
    localparam logic [1:0] SDA_ONE  = 2'd1;
    localparam logic [1:0] SDA_ZERO = 2'd2;
    localparam logic [1:0] SDA_TX   = 2'd3;

    typedef struct packed {
        logic       load;     // capture request payload
        logic       go;       // emit one step into the output register
        logic       scl;
        logic [1:0] sda_sel;
        logic [2:0] hold;
        logic       last;
        logic       rx_out;   // show received byte on this step
        logic       ack_out;  // show ack level on this step
        logic       shift;    // advance transmit shifter after this step
    } step_cmd_t;

    typedef struct packed {
        logic out_free;       // output register can take a step this cycle
    } dp_status_t;

endpackage

### rtl/i2cmbs_ctrl.sv
// ----------------------------------------------------------------------------
// i2cmbs_ctrl
// command state machine: walks the step run of one bus command
// ----------------------------------------------------------------------------
module i2cmbs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_op,
    input  i2cmbs_pkg::dp_status_t sts,
    output i2cmbs_pkg::step_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                         state_reg, state_next;
    logic [2:0]                   op_reg, op_next;
    logic [i2cmbs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                   phase_reg, phase_next;
    logic                         accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // step decode
    always_comb begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.go      = (state_reg == ST_RUN) && sts.out_free;
        cmd.sda_sel = i2cmbs_pkg::SDA_ONE;
        cmd.hold    = i2cmbs_pkg::HOLD_4;
        unique case (op_reg)
            i2cmbs_pkg::OP_START: begin
                if (cnt_reg == '0) begin
                    cmd.scl  = 1'b1;
                    cmd.hold = i2cmbs_pkg::HOLD_5;
                end else if (cnt_reg == 5'd1) begin
                    cmd.scl     = 1'b1;
                    cmd.sda_sel = i2cmbs_pkg::SDA_ZERO;
                end else begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_ZERO;
                    cmd.hold    = i2cmbs_pkg::HOLD_0;
                    cmd.last    = 1'b1;
                end
            end
            i2cmbs_pkg::OP_STOP: begin
                if (cnt_reg == '0) begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_ZERO;
                end else if (cnt_reg == 5'd1) begin
                    cmd.scl     = 1'b1;
                    cmd.sda_sel = i2cmbs_pkg::SDA_ZERO;
                end else begin
                    cmd.scl  = 1'b1;
                    cmd.hold = i2cmbs_pkg::HOLD_5;
                    cmd.last = 1'b1;
                end
            end
            i2cmbs_pkg::OP_SEND: begin
                if (cnt_reg == i2cmbs_pkg::SEND_LAST) begin
                    cmd.last = 1'b1;
                end else if (cnt_reg == i2cmbs_pkg::SEND_TAIL) begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_HELD;
                end else if (phase_reg == 2'd0) begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_HELD;
                end else if (phase_reg == 2'd1) begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_TX;
                end else begin
                    cmd.scl     = 1'b1;
                    cmd.sda_sel = i2cmbs_pkg::SDA_TX;
                    cmd.shift   = 1'b1;
                end
            end
            i2cmbs_pkg::OP_RECV: begin
                if (cnt_reg == i2cmbs_pkg::RECV_LAST) begin
                    cmd.last   = 1'b1;
                    cmd.rx_out = 1'b1;
                end else if (cnt_reg == '0) begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_HELD;
                end else begin
                    cmd.scl = cnt_reg[0];
                end
            end
            i2cmbs_pkg::OP_ACK: begin
                if (cnt_reg == '0) begin
                    cmd.scl  = 1'b1;
                    cmd.hold = i2cmbs_pkg::HOLD_0;
                end else begin
                    cmd.hold    = i2cmbs_pkg::HOLD_1;
                    cmd.last    = 1'b1;
                    cmd.ack_out = 1'b1;
                end
            end
            default: begin
                if (cnt_reg == '0) begin
                    cmd.scl = 1'b1;
                end else begin
                    cmd.sda_sel = i2cmbs_pkg::SDA_ZERO;
                    cmd.hold    = i2cmbs_pkg::HOLD_0;
                    cmd.last    = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op <= i2cmbs_pkg::OP_NACK)) begin
                    state_next = ST_RUN;
                    op_next    = s_op;
                    cnt_next   = '0;
                    phase_next = '0;
                end
            end
            default: begin
                if (cmd.go) begin
                    cnt_next   = cnt_reg + 1'b1;
                    phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 1'b1;
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= i2cmbs_pkg::OP_START;
            cnt_reg   <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### rtl/i2cmbs_dpath.sv
// ----------------------------------------------------------------------------
// i2cmbs_dpath
// payload capture, transmit shifter, held sda level and step output register
// ----------------------------------------------------------------------------
module i2cmbs_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_wr_data,
    input  logic [7:0]             s_line_sample,
    input  i2cmbs_pkg::step_cmd_t  cmd,
    output i2cmbs_pkg::dp_status_t sts,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_scl_level,
    output logic                   m_sda_level,
    output logic [2:0]             m_hold_us,
    output logic [7:0]             m_rx_byte,
    output logic                   m_ack_missing,
    output logic                   m_last
);

    logic [7:0] tx_reg;
    logic [7:0] rx_reg;
    logic       sda_held_reg;
    logic       m_valid_reg, m_valid_next;
    logic       scl_out_reg;
    logic       sda_out_reg;
    logic [2:0] hold_out_reg;
    logic [7:0] rx_out_reg;
    logic       ack_out_reg;
    logic       last_out_reg;
    logic       sda_step;

    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd.sda_sel)
            i2cmbs_pkg::SDA_HELD: sda_step = sda_held_reg;
            i2cmbs_pkg::SDA_ZERO: sda_step = 1'b0;
            i2cmbs_pkg::SDA_TX:   sda_step = tx_reg[7];
            default:              sda_step = 1'b1;
        endcase
    end

    assign m_valid_next = cmd.go ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sda_held_reg <= 1'b1;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.go) begin
                sda_held_reg <= sda_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tx_reg <= s_wr_data;
            rx_reg <= s_line_sample;
        end else if (cmd.go && cmd.shift) begin
            tx_reg <= {tx_reg[6:0], 1'b0};
        end
        if (cmd.go) begin
            scl_out_reg  <= cmd.scl;
            sda_out_reg  <= sda_step;
            hold_out_reg <= cmd.hold;
            rx_out_reg   <= cmd.rx_out ? rx_reg : 8'd0;
            ack_out_reg  <= cmd.ack_out & rx_reg[0];
            last_out_reg <= cmd.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_scl_level   = scl_out_reg;
    assign m_sda_level   = sda_out_reg;
    assign m_hold_us     = hold_out_reg;
    assign m_rx_byte     = rx_out_reg;
    assign m_ack_missing = ack_out_reg;
    assign m_last        = last_out_reg;

endmodule

### rtl/i2c_master_bit_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// byte-level i2c master: turns one bus command into a run of pin steps
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | op, wr_data, line_sample
//  m_       | out       | scl_level, sda_level, hold_us, rx_byte,
//           |           | ack_missing, last
//
//  one request at a time: s_ready is high only while no run is in progress
//  a run emits one step per cycle while the output register drains; the
//  step counter in the controller sets the run length (3, 2, 18 or 26 steps)
//  m_ready low stalls the run; the next request is taken while the final
//  step still waits in the output register
//  unused op codes are taken and give no steps
//  reset (aresetn low, synchronous) empties the output and idles the bus
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  logic       aclk,
    input  logic       aresetn,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [7:0] s_wr_data,
    input  logic [7:0] s_line_sample,
    // step channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic [2:0] m_hold_us,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_missing,
    output logic       m_last
);

    // step command from the state machine, status back from the datapath
    i2cmbs_pkg::step_cmd_t  cmd;
    i2cmbs_pkg::dp_status_t sts;

    // controller: decodes the command into per-step pin levels and timing
    i2cmbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: shifts data, tracks held sda and registers each step
    i2cmbs_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_wr_data     (s_wr_data),
        .s_line_sample (s_line_sample),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_level   (m_scl_level),
        .m_sda_level   (m_sda_level),
        .m_hold_us     (m_hold_us),
        .m_rx_byte     (m_rx_byte),
        .m_ack_missing (m_ack_missing),
        .m_last        (m_last)
    );

endmodule
